### src/lbmeq_pkg.sv
// lbmeq_pkg: shared constants, types and helpers for the d2q9 open boundary
// equilibrium block. Used by lbmeq_lane and the top level. No dependencies.

package lbmeq_pkg;

  localparam int NumStages = 9;
  localparam int FracBits  = 14;
  localparam int NumLanes  = 4;
  localparam int NumProd   = 5;

  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 18;

  // register indexes on the configuration port
  localparam logic [CfgIdxW-1:0] RegLinear    = 3'd0;
  localparam logic [CfgIdxW-1:0] RegQuadratic = 3'd1;
  localparam logic [CfgIdxW-1:0] RegAxis      = 3'd2;
  localparam logic [CfgIdxW-1:0] RegDiagonal  = 3'd3;
  localparam logic [CfgIdxW-1:0] RegInlet     = 3'd4;
  localparam logic [CfgIdxW-1:0] RegRest      = 3'd5;

  localparam logic [17:0]        LinearReset    = 18'd49152;
  localparam logic [17:0]        QuadraticReset = 18'd24576;
  localparam logic [17:0]        AxisReset      = 18'd1820;
  localparam logic [17:0]        DiagonalReset  = 18'd455;
  localparam logic signed [15:0] InletReset     = 16'sd1638;

  typedef logic [NumStages-1:0] stage_en_t;
  typedef logic signed [19:0]   proj_t;
  typedef logic signed [37:0]   vsq_t;
  typedef logic signed [31:0]   cxo_t;

  function automatic logic signed [15:0] sat16(input logic signed [36:0] val);
    logic signed [15:0] res;
    if (val > 37'sd32767) begin
      res = 16'sh7fff;
    end else if (val < -37'sd32768) begin
      res = 16'sh8000;
    end else begin
      res = val[15:0];
    end
    return res;
  endfunction

endpackage

### src/lbmeq_lane.sv
// lbmeq_lane: equilibrium core for one projection, pipeline stages 3 to 7.
// Produces round(s / 2^28) plus the optional rest offset. Depends on lbmeq_pkg.

module lbmeq_lane (
  input  logic                  clk,
  input  lbmeq_pkg::stage_en_t  en,
  input  lbmeq_pkg::proj_t      c,
  input  lbmeq_pkg::vsq_t       vsq,
  input  logic                  self_sq,
  input  logic [17:0]           linear_factor,
  input  logic [17:0]           quadratic_factor,
  input  logic                  rest_offset_on,
  output lbmeq_pkg::cxo_t       cx
);

  logic signed [18:0] lf_s;
  logic signed [18:0] qf_s;
  logic signed [39:0] csq_full;
  logic signed [38:0] lin_full;
  logic signed [39:0] csq_ext;
  logic signed [39:0] v_ext;
  logic signed [20:0] d_lo;
  logic signed [19:0] d_hi;
  logic signed [39:0] pp_lo_full;
  logic signed [38:0] pp_hi_full;
  logic        [59:0] s_sum;

  logic signed [38:0] csq;
  logic signed [38:0] lin_s3;
  logic signed [38:0] lin_s4;
  logic signed [38:0] lin_s5;
  logic signed [38:0] lin_s6;
  logic signed [39:0] d;
  logic signed [39:0] pp_lo;
  logic signed [38:0] pp_hi;
  logic signed [59:0] quad;

  assign lf_s       = $signed({1'b0, linear_factor});
  assign qf_s       = $signed({1'b0, quadratic_factor});
  assign csq_full   = c * c;
  assign lin_full   = lf_s * c;
  assign csq_ext    = {csq[38], csq};
  assign v_ext      = self_sq ? csq_ext : {{2{vsq[37]}}, vsq};
  assign d_lo       = $signed({1'b0, d[19:0]});
  assign d_hi       = d[39:20];
  assign pp_lo_full = qf_s * d_lo;
  assign pp_hi_full = qf_s * d_hi;
  assign s_sum      = quad + {{7{lin_s6[38]}}, lin_s6, 14'b0} + 60'd134217728;

  // square of the projection and linear term
  always_ff @(posedge clk) begin
    if (en[2]) begin
      csq    <= csq_full[38:0];
      lin_s3 <= lin_full;
    end
  end

  // 3c^2 - v
  always_ff @(posedge clk) begin
    if (en[3]) begin
      d      <= (csq_ext <<< 1) + csq_ext - v_ext;
      lin_s4 <= lin_s3;
    end
  end

  // quadratic factor as two partial products
  always_ff @(posedge clk) begin
    if (en[4]) begin
      pp_lo  <= pp_lo_full;
      pp_hi  <= pp_hi_full;
      lin_s5 <= lin_s4;
    end
  end

  always_ff @(posedge clk) begin
    if (en[5]) begin
      quad   <= $signed({pp_hi[38], pp_hi, 20'b0}) + $signed({{20{pp_lo[39]}}, pp_lo});
      lin_s6 <= lin_s5;
    end
  end

  // round to q.14 and add rest offset
  always_ff @(posedge clk) begin
    if (en[6]) begin
      cx <= $signed(s_sum[59:28]) + (rest_offset_on ? 32'sd16384 : 32'sd0);
    end
  end

endmodule

### src/lbm_d2q9_open_boundary_equilibrium.sv
// lbm_d2q9_open_boundary_equilibrium: top level, momentum, config registers,
// weighting and saturation. Depends on lbmeq_pkg and lbmeq_lane.
//
//   channel   handshake              payload
//   in        in_valid / in_ready    pop_* (eight populations, q2.14)
//   out       out_valid / out_ready  ghost_* and inlet_* (six populations)
//   cfg       cfg_valid / cfg_ready  cfg_index, cfg_data
//
// nine register stages, one row per cycle while the output is not stalled
// each stage holds while the stage after it is full and stalled
// in_ready falls only when every stage holds a row
// synchronous reset empties the pipe and loads the default registers
// cfg_ready is always high

module lbm_d2q9_open_boundary_equilibrium (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [15:0]                  pop_east_north,
  input  logic signed [15:0]                  pop_east_south,
  input  logic signed [15:0]                  pop_east,
  input  logic signed [15:0]                  pop_south,
  input  logic signed [15:0]                  pop_west_south,
  input  logic signed [15:0]                  pop_west_north,
  input  logic signed [15:0]                  pop_west,
  input  logic signed [15:0]                  pop_north,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [15:0]                  ghost_west_south,
  output logic signed [15:0]                  ghost_west_north,
  output logic signed [15:0]                  ghost_west,
  output logic signed [15:0]                  inlet_east_north,
  output logic signed [15:0]                  inlet_east_south,
  output logic signed [15:0]                  inlet_east,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [lbmeq_pkg::CfgIdxW-1:0]       cfg_index,
  input  logic [lbmeq_pkg::CfgDataW-1:0]      cfg_data
);

  logic [17:0]        linear_factor;
  logic [17:0]        quadratic_factor;
  logic [17:0]        axis_weight;
  logic [17:0]        diagonal_weight;
  logic signed [15:0] inlet_velocity;
  logic               rest_offset_on;

  logic [lbmeq_pkg::NumStages-1:0] vld;
  lbmeq_pkg::stage_en_t            rdy;

  logic signed [18:0] x_next;
  logic signed [18:0] y_next;
  logic signed [18:0] x;
  logic signed [18:0] y;
  logic signed [37:0] xsq;
  logic signed [37:0] ysq;
  lbmeq_pkg::vsq_t    vsq;
  lbmeq_pkg::proj_t   c  [lbmeq_pkg::NumLanes];
  lbmeq_pkg::cxo_t    cx [lbmeq_pkg::NumLanes];
  logic signed [18:0] wa_s;
  logic signed [18:0] wd_s;
  logic signed [50:0] prod [lbmeq_pkg::NumProd];
  logic signed [15:0] res  [lbmeq_pkg::NumProd];

  assign cfg_ready = 1'b1;
  assign in_ready  = rdy[0];
  assign out_valid = vld[lbmeq_pkg::NumStages-1];

  // a stage takes a new row when empty or when its row moves on
  always_comb begin
    rdy[lbmeq_pkg::NumStages-1] = !vld[lbmeq_pkg::NumStages-1] || out_ready;
    for (int k = lbmeq_pkg::NumStages - 2; k >= 0; k--) begin
      rdy[k] = !vld[k] || rdy[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[0]) begin
        vld[0] <= in_valid;
      end
      for (int k = 1; k < lbmeq_pkg::NumStages; k++) begin
        if (rdy[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      linear_factor    <= lbmeq_pkg::LinearReset;
      quadratic_factor <= lbmeq_pkg::QuadraticReset;
      axis_weight      <= lbmeq_pkg::AxisReset;
      diagonal_weight  <= lbmeq_pkg::DiagonalReset;
      inlet_velocity   <= lbmeq_pkg::InletReset;
      rest_offset_on   <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        lbmeq_pkg::RegLinear:    linear_factor    <= cfg_data;
        lbmeq_pkg::RegQuadratic: quadratic_factor <= cfg_data;
        lbmeq_pkg::RegAxis:      axis_weight      <= cfg_data;
        lbmeq_pkg::RegDiagonal:  diagonal_weight  <= cfg_data;
        lbmeq_pkg::RegInlet:     inlet_velocity   <= $signed(cfg_data[15:0]);
        lbmeq_pkg::RegRest:      rest_offset_on   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // momentum with unit density
  assign x_next = (19'(pop_east_south) - 19'(pop_west_north))
                + (19'(pop_east_north) - 19'(pop_west_south))
                + (19'(pop_east) - 19'(pop_west));
  assign y_next = (19'(pop_east_south) - 19'(pop_east_north))
                + (19'(pop_west_north) - 19'(pop_west_south))
                + (19'(pop_south) - 19'(pop_north));

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      x <= x_next;
      y <= y_next;
    end
  end

  // projections and squared momentum
  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      c[0] <= -20'(x) - 20'(y);
      c[1] <= -20'(x) + 20'(y);
      c[2] <= -20'(x);
      c[3] <= 20'(inlet_velocity);
      xsq  <= x * x;
      ysq  <= y * y;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      vsq <= xsq + ysq;
    end
  end

  for (genvar g = 0; g < lbmeq_pkg::NumLanes; g++) begin : g_lane
    lbmeq_lane u_lane (
      .clk              (clk),
      .en               (rdy),
      .c                (c[g]),
      .vsq              (vsq),
      .self_sq          (g == lbmeq_pkg::NumLanes - 1),
      .linear_factor    (linear_factor),
      .quadratic_factor (quadratic_factor),
      .rest_offset_on   (rest_offset_on),
      .cx               (cx[g])
    );
  end

  assign wa_s = $signed({1'b0, axis_weight});
  assign wd_s = $signed({1'b0, diagonal_weight});

  // lattice weights, inlet lane feeds both diagonal and axis products
  always_ff @(posedge clk) begin
    if (rdy[7]) begin
      prod[0] <= wd_s * cx[0];
      prod[1] <= wd_s * cx[1];
      prod[2] <= wa_s * cx[2];
      prod[3] <= wd_s * cx[3];
      prod[4] <= wa_s * cx[3];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[8]) begin
      for (int k = 0; k < lbmeq_pkg::NumProd; k++) begin
        res[k] <= lbmeq_pkg::sat16(37'((prod[k] + 51'sd8192) >>> lbmeq_pkg::FracBits));
      end
    end
  end

  assign ghost_west_south = res[0];
  assign ghost_west_north = res[1];
  assign ghost_west       = res[2];
  assign inlet_east_north = res[3];
  assign inlet_east_south = res[3];
  assign inlet_east       = res[4];

endmodule

### src/lbmeq_check.sv
// lbmeq_check: port level checks for lbm_d2q9_open_boundary_equilibrium,
// bound to the top level. Depends on lbmeq_pkg and the top level's ports.

module lbmeq_check (
  input logic                                clk,
  input logic                                rst,
  input logic                                in_valid,
  input logic                                in_ready,
  input logic signed [15:0]                  pop_east_north,
  input logic signed [15:0]                  pop_east_south,
  input logic signed [15:0]                  pop_east,
  input logic signed [15:0]                  pop_south,
  input logic signed [15:0]                  pop_west_south,
  input logic signed [15:0]                  pop_west_north,
  input logic signed [15:0]                  pop_west,
  input logic signed [15:0]                  pop_north,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic signed [15:0]                  ghost_west_south,
  input logic signed [15:0]                  ghost_west_north,
  input logic signed [15:0]                  ghost_west,
  input logic signed [15:0]                  inlet_east_north,
  input logic signed [15:0]                  inlet_east_south,
  input logic signed [15:0]                  inlet_east,
  input logic                                cfg_valid,
  input logic                                cfg_ready,
  input logic [lbmeq_pkg::CfgIdxW-1:0]       cfg_index,
  input logic [lbmeq_pkg::CfgDataW-1:0]      cfg_data
);

  // pipe is empty right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  // an empty output stage never blocks the input
  a_ready_free: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output stage");

  // both inlet diagonals share weight and projection
  a_inlet_diag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> inlet_east_north == inlet_east_south)
    else $error("inlet diagonal populations differ");

  // a stalled transfer stays valid and holds ghost_west and inlet_east
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(ghost_west) && $stable(inlet_east))
    else $error("stalled result changed");

endmodule

bind lbm_d2q9_open_boundary_equilibrium lbmeq_check u_lbmeq_check (.*);

### sim/testbench.sv
// testbench for lbm_d2q9_open_boundary_equilibrium: drives outlet population rows and
// register writes, predicts the ghost and inlet equilibria of each row and checks them
// in order. Depends on lbmeq_pkg and the block's RTL.

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [lbmeq_pkg::CfgIdxW-1:0] RegSpareLow  = 3'd6;
  localparam logic [lbmeq_pkg::CfgIdxW-1:0] RegSpareHigh = 3'd7;
  localparam int Fb = lbmeq_pkg::FracBits;

  typedef struct packed {
    logic signed [15:0] east_north, east_south, east, south;
    logic signed [15:0] west_south, west_north, west, north;
  } pop_row_t;

  typedef struct packed {
    logic signed [15:0] ghost_west_south, ghost_west_north, ghost_west;
    logic signed [15:0] inlet_east_north, inlet_east_south, inlet_east;
  } eq_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  pop_row_t in_row = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [15:0] gh_ws, gh_wn, gh_w, il_en, il_es, il_e;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [lbmeq_pkg::CfgIdxW-1:0] cfg_index = '0;
  logic [lbmeq_pkg::CfgDataW-1:0] cfg_data = '0;

  // register shadow
  longint cfg_linear = lbmeq_pkg::LinearReset;
  longint cfg_quadratic = lbmeq_pkg::QuadraticReset;
  longint cfg_axis = lbmeq_pkg::AxisReset;
  longint cfg_diagonal = lbmeq_pkg::DiagonalReset;
  longint cfg_inlet = lbmeq_pkg::InletReset;
  longint cfg_rest = 0;

  pop_row_t rows_to_send[$];
  eq_row_t expected_rows[$];
  eq_row_t got_row, want_row;
  int idle_pct = 0;
  int stall_pct = 0;
  int rx_hold_left = 0;
  logic send_hold = 1'b0;
  int mismatches = 0;
  int rows_checked = 0;

  always #6 clk = ~clk;

  lbm_d2q9_open_boundary_equilibrium dut (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .pop_east_north   (in_row.east_north),
    .pop_east_south   (in_row.east_south),
    .pop_east         (in_row.east),
    .pop_south        (in_row.south),
    .pop_west_south   (in_row.west_south),
    .pop_west_north   (in_row.west_north),
    .pop_west         (in_row.west),
    .pop_north        (in_row.north),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .ghost_west_south (gh_ws),
    .ghost_west_north (gh_wn),
    .ghost_west       (gh_w),
    .inlet_east_north (il_en),
    .inlet_east_south (il_es),
    .inlet_east       (il_e),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  function automatic logic signed [15:0] eq_pop(longint weight, longint proj, longint vsq);
    longint s, cx, r;
    s = cfg_linear * proj * (longint'(1) << Fb) + cfg_quadratic * (3 * proj * proj - vsq);
    cx = (s + (longint'(1) << (2 * Fb - 1))) >>> (2 * Fb);
    r = (weight * (cx + ((cfg_rest != 0) ? (longint'(1) << Fb) : 0))
         + (longint'(1) << (Fb - 1))) >>> Fb;
    if (r > 32767) begin
      r = 32767;
    end else if (r < -32768) begin
      r = -32768;
    end
    return r[15:0];
  endfunction

  function automatic eq_row_t predict_boundary(pop_row_t p);
    longint x, y, v;
    eq_row_t r;
    x = (longint'(p.east_south) - longint'(p.west_north))
        + (longint'(p.east_north) - longint'(p.west_south))
        + (longint'(p.east) - longint'(p.west));
    y = (longint'(p.east_south) - longint'(p.east_north))
        + (longint'(p.west_north) - longint'(p.west_south))
        + (longint'(p.south) - longint'(p.north));
    v = x * x + y * y;
    r.ghost_west_south = eq_pop(cfg_diagonal, -x - y, v);
    r.ghost_west_north = eq_pop(cfg_diagonal, -x + y, v);
    r.ghost_west       = eq_pop(cfg_axis, -x, v);
    r.inlet_east_north = eq_pop(cfg_diagonal, cfg_inlet, cfg_inlet * cfg_inlet);
    r.inlet_east_south = eq_pop(cfg_diagonal, cfg_inlet, cfg_inlet * cfg_inlet);
    r.inlet_east       = eq_pop(cfg_axis, cfg_inlet, cfg_inlet * cfg_inlet);
    return r;
  endfunction

  function automatic logic signed [15:0] rand_pop(int flavour);
    logic signed [15:0] val;
    case (flavour)
      0: begin
        val = 16'($urandom_range(0, 4000));
      end
      1: begin
        val = 16'($urandom);
      end
      default: begin
        case ($urandom_range(0, 4))
          0: val = 16'sh7fff;
          1: val = 16'sh8000;
          2: val = 16'sh0000;
          3: val = 16'shffff;
          default: val = 16'($urandom);
        endcase
      end
    endcase
    return val;
  endfunction

  function automatic pop_row_t rand_row();
    int pick, flavour;
    pop_row_t r;
    pick = $urandom_range(0, 9);
    flavour = (pick < 4) ? 0 : ((pick < 7) ? 1 : 2);
    r.east_north = rand_pop(flavour);
    r.east_south = rand_pop(flavour);
    r.east       = rand_pop(flavour);
    r.south      = rand_pop(flavour);
    r.west_south = rand_pop(flavour);
    r.west_north = rand_pop(flavour);
    r.west       = rand_pop(flavour);
    r.north      = rand_pop(flavour);
    return r;
  endfunction

  function automatic logic [17:0] rand_factor();
    logic [17:0] val;
    case ($urandom_range(0, 3))
      0: val = $urandom_range(0, 1) ? 18'h3ffff : 18'h00000;
      1: val = 18'($urandom);
      default: val = 18'($urandom_range(0, 65535));
    endcase
    return val;
  endfunction

  task automatic queue_random(int n);
    repeat (n) rows_to_send.push_back(rand_row());
  endtask

  // settle: wait until nothing is pending and nothing is in flight
  task automatic drain();
    while (rows_to_send.size() != 0 || in_valid || expected_rows.size() != 0) begin
      @(negedge clk);
    end
    repeat (12) @(negedge clk);
  endtask

  task automatic write_reg(logic [lbmeq_pkg::CfgIdxW-1:0] idx, logic [17:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      lbmeq_pkg::RegLinear:    cfg_linear = longint'(data);
      lbmeq_pkg::RegQuadratic: cfg_quadratic = longint'(data);
      lbmeq_pkg::RegAxis:      cfg_axis = longint'(data);
      lbmeq_pkg::RegDiagonal:  cfg_diagonal = longint'(data);
      lbmeq_pkg::RegInlet:     cfg_inlet = longint'(signed'(data[15:0]));
      lbmeq_pkg::RegRest:      cfg_rest = longint'(data[0]);
      default: ;
    endcase
  endtask

  // row driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        expected_rows.push_back(predict_boundary(in_row));
      end
      if (!in_valid || in_ready) begin
        if (rows_to_send.size() != 0 && !send_hold && $urandom_range(99) >= idle_pct) begin
          in_row   <= rows_to_send.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off
  always @(posedge clk) begin
    if (rx_hold_left != 0) begin
      rx_hold_left <= rx_hold_left - 1;
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        got_row = '{gh_ws, gh_wn, gh_w, il_en, il_es, il_e};
        if (expected_rows.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("unexpected transfer: %0d %0d %0d %0d %0d %0d",
                     gh_ws, gh_wn, gh_w, il_en, il_es, il_e);
          end
        end else begin
          want_row = expected_rows.pop_front();
          if (got_row.ghost_west_south !== want_row.ghost_west_south
              || got_row.ghost_west_north !== want_row.ghost_west_north
              || got_row.ghost_west !== want_row.ghost_west
              || got_row.inlet_east_north !== want_row.inlet_east_north
              || got_row.inlet_east_south !== want_row.inlet_east_south
              || got_row.inlet_east !== want_row.inlet_east) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("row %0d expected %0d %0d %0d %0d %0d %0d got %0d %0d %0d %0d %0d %0d",
                       rows_checked, want_row.ghost_west_south, want_row.ghost_west_north,
                       want_row.ghost_west, want_row.inlet_east_north,
                       want_row.inlet_east_south, want_row.inlet_east,
                       gh_ws, gh_wn, gh_w, il_en, il_es, il_e);
            end
          end
        end
        rows_checked++;
      end
      out_ready <= (rx_hold_left == 0) && ($urandom_range(99) >= stall_pct);
    end
  end

  initial begin
    #2_400_000;
    $display("testbench failed");
    $finish;
  end

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed rows at reset settings
    rows_to_send.push_back('0);
    rows_to_send.push_back({8{16'sh7fff}});
    rows_to_send.push_back({8{16'sh8000}});
    rows_to_send.push_back('{16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh0000,
                             16'sh8000, 16'sh8000, 16'sh8000, 16'sh0000});
    rows_to_send.push_back('{16'sh8000, 16'sh8000, 16'sh8000, 16'sh0000,
                             16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh0000});
    rows_to_send.push_back('{16'sh8000, 16'sh7fff, 16'sh0000, 16'sh7fff,
                             16'sh8000, 16'sh7fff, 16'sh0000, 16'sh8000});
    rows_to_send.push_back('{16'sh7fff, 16'sh8000, 16'sh0000, 16'sh8000,
                             16'sh7fff, 16'sh8000, 16'sh0000, 16'sh7fff});
    rows_to_send.push_back('{16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff,
                             16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000});
    rows_to_send.push_back('{16'sd455, 16'sd455, 16'sd1820, 16'sd1820,
                             16'sd455, 16'sd455, 16'sd1820, 16'sd1820});
    rows_to_send.push_back('{16'sd600, 16'sd500, 16'sd2300, 16'sd1800,
                             16'sd400, 16'sd420, 16'sd1500, 16'sd1830});
    rows_to_send.push_back({8{16'shffff}});
    rows_to_send.push_back({8{16'sh0001}});
    rows_to_send.push_back({8{16'sh5555}});
    rows_to_send.push_back({8{16'shaaaa}});
    rows_to_send.push_back('{16'sh0001, 16'sh0000, 16'sh0000, 16'sh0000,
                             16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000});
    rows_to_send.push_back('{16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000,
                             16'sh0000, 16'sh0000, 16'sh0001, 16'sh0000});
    drain();

    for (int phase = 0; phase < 10; phase++) begin
      case (phase)
        0: ;
        1: begin
          write_reg(lbmeq_pkg::RegLinear, 18'h3ffff);
          write_reg(lbmeq_pkg::RegQuadratic, 18'h3ffff);
          write_reg(lbmeq_pkg::RegAxis, 18'h3ffff);
          write_reg(lbmeq_pkg::RegDiagonal, 18'h3ffff);
          write_reg(lbmeq_pkg::RegInlet, 18'h38000);
          write_reg(lbmeq_pkg::RegRest, 18'h3ffff);
          write_reg(RegSpareLow, 18'($urandom));
          write_reg(RegSpareHigh, 18'($urandom));
        end
        2: begin
          write_reg(lbmeq_pkg::RegLinear, 18'h00000);
          write_reg(lbmeq_pkg::RegQuadratic, 18'h00000);
          write_reg(lbmeq_pkg::RegAxis, 18'h00000);
          write_reg(lbmeq_pkg::RegDiagonal, 18'h00000);
          write_reg(lbmeq_pkg::RegInlet, 18'h00000);
          write_reg(lbmeq_pkg::RegRest, 18'h3fffe);
        end
        3: begin
          write_reg(lbmeq_pkg::RegLinear, lbmeq_pkg::LinearReset);
          write_reg(lbmeq_pkg::RegQuadratic, lbmeq_pkg::QuadraticReset);
          write_reg(lbmeq_pkg::RegAxis, lbmeq_pkg::AxisReset);
          write_reg(lbmeq_pkg::RegDiagonal, lbmeq_pkg::DiagonalReset);
          write_reg(lbmeq_pkg::RegInlet, 18'h07fff);
          write_reg(lbmeq_pkg::RegRest, 18'h00001);
        end
        default: begin
          write_reg(lbmeq_pkg::RegLinear, rand_factor());
          write_reg(lbmeq_pkg::RegQuadratic, rand_factor());
          write_reg(lbmeq_pkg::RegAxis, rand_factor());
          write_reg(lbmeq_pkg::RegDiagonal, rand_factor());
          write_reg(lbmeq_pkg::RegInlet, 18'($urandom));
          write_reg(lbmeq_pkg::RegRest, 18'($urandom));
          if (phase == 7) begin
            write_reg(RegSpareLow, 18'($urandom));
            write_reg(RegSpareHigh, 18'($urandom));
          end
        end
      endcase
      @(negedge clk);

      if (phase == 5) begin
        // receiver holds off while rows keep coming, so the pipe backs up
        idle_pct = 0;
        stall_pct = 0;
        rx_hold_left = 300;
        queue_random(80);
        drain();
        // sender stops mid-stream until every result is back
        queue_random(100);
        while (rows_to_send.size() > 50) @(negedge clk);
        send_hold = 1'b1;
        while (in_valid || expected_rows.size() != 0) @(negedge clk);
        send_hold = 1'b0;
        drain();
      end

      case (phase % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 56; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 56; end
        default: begin idle_pct = 32; stall_pct = 32; end
      endcase
      queue_random(125);
      drain();
    end

    repeat (20) @(posedge clk);
    if (expected_rows.size() != 0) begin
      $display("%0d results never arrived", expected_rows.size());
      mismatches += expected_rows.size();
    end
    if (mismatches == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
